>>> hw/rtl/gcb_pkg.sv
// Shared types, register indexes, probe pattern and helper functions for the
// grid cell binning block. Used by gcb_ctrl, gcb_datapath and grid_cell_binning.
`default_nettype none

package gcb_pkg;

  localparam int unsigned MaxSideCellsDefault = 64;
  localparam int unsigned ProbeCount = 27;
  localparam logic [4:0] LAST_PROBE = 5'(ProbeCount - 1);

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_CELL_SCALE = 3'd3;
  localparam logic [2:0] REG_CELLS_PER_SIDE = 3'd4;

  // Sign codes of a probe offset along one axis.
  localparam logic [1:0] SGN_NEG = 2'd0;
  localparam logic [1:0] SGN_ZERO = 2'd1;
  localparam logic [1:0] SGN_POS = 2'd2;

  // Axis codes.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_MUL,
    S_FIN,
    S_SCL,
    S_SCAN,
    S_FLUSH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       sub;
    logic       mul;
    logic       fin;
    logic       scl;
    logic       scan_adv;
    logic       flush;
    logic [1:0] axis;
    logic [1:0] sgn;
    logic [4:0] probe;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic probe_hit;
    logic pend_valid;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [1:0] sx;
    logic [1:0] sy;
    logic [1:0] sz;
  } probe_sign_t;

  // Probe pattern: centre, the six faces, the xy edges, the +z ring, the -z ring.
  function automatic probe_sign_t probe_sign(input logic [4:0] p);
    probe_sign_t s;
    case (p)
      5'd0:  s = '{SGN_ZERO, SGN_ZERO, SGN_ZERO};
      5'd1:  s = '{SGN_ZERO, SGN_ZERO, SGN_POS};
      5'd2:  s = '{SGN_ZERO, SGN_ZERO, SGN_NEG};
      5'd3:  s = '{SGN_POS,  SGN_ZERO, SGN_ZERO};
      5'd4:  s = '{SGN_NEG,  SGN_ZERO, SGN_ZERO};
      5'd5:  s = '{SGN_ZERO, SGN_POS,  SGN_ZERO};
      5'd6:  s = '{SGN_ZERO, SGN_NEG,  SGN_ZERO};
      5'd7:  s = '{SGN_POS,  SGN_POS,  SGN_ZERO};
      5'd8:  s = '{SGN_POS,  SGN_NEG,  SGN_ZERO};
      5'd9:  s = '{SGN_NEG,  SGN_POS,  SGN_ZERO};
      5'd10: s = '{SGN_NEG,  SGN_NEG,  SGN_ZERO};
      5'd11: s = '{SGN_POS,  SGN_ZERO, SGN_POS};
      5'd12: s = '{SGN_NEG,  SGN_ZERO, SGN_POS};
      5'd13: s = '{SGN_ZERO, SGN_POS,  SGN_POS};
      5'd14: s = '{SGN_ZERO, SGN_NEG,  SGN_POS};
      5'd15: s = '{SGN_POS,  SGN_POS,  SGN_POS};
      5'd16: s = '{SGN_POS,  SGN_NEG,  SGN_POS};
      5'd17: s = '{SGN_NEG,  SGN_POS,  SGN_POS};
      5'd18: s = '{SGN_NEG,  SGN_NEG,  SGN_POS};
      5'd19: s = '{SGN_POS,  SGN_ZERO, SGN_NEG};
      5'd20: s = '{SGN_NEG,  SGN_ZERO, SGN_NEG};
      5'd21: s = '{SGN_ZERO, SGN_POS,  SGN_NEG};
      5'd22: s = '{SGN_ZERO, SGN_NEG,  SGN_NEG};
      5'd23: s = '{SGN_POS,  SGN_POS,  SGN_NEG};
      5'd24: s = '{SGN_POS,  SGN_NEG,  SGN_NEG};
      5'd25: s = '{SGN_NEG,  SGN_POS,  SGN_NEG};
      5'd26: s = '{SGN_NEG,  SGN_NEG,  SGN_NEG};
      default: s = '{SGN_ZERO, SGN_ZERO, SGN_ZERO};
    endcase
    return s;
  endfunction

  // A probe repeats an earlier one when every axis lands in the same valid cell.
  // Each mask is indexed by {sign_a, sign_b} and is set when both signs hit the
  // same in-range cell on that axis.
  function automatic logic probe_is_dup(input logic [4:0] p, input logic [15:0] eqx,
                                        input logic [15:0] eqy, input logic [15:0] eqz);
    probe_sign_t t;
    probe_sign_t s;
    logic        dup;
    t = probe_sign(p);
    dup = 1'b0;
    for (int q = 0; q < ProbeCount; q++) begin
      s = probe_sign(5'(q));
      if (5'(q) < p && eqx[{s.sx, t.sx}] && eqy[{s.sy, t.sy}] && eqz[{s.sz, t.sz}]) begin
        dup = 1'b1;
      end
    end
    return dup;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/grid_cell_binning.sv
// Top level of the grid cell binning block: joins the controller and the
// datapath. Depends on gcb_pkg, gcb_ctrl and gcb_datapath.
//
// Usage: each request on the input channel carries an entity id, a centre and
// a radius. The block sends one result request per distinct grid cell touched
// by the 27 probe points, in order of first hit, with last set on the final
// one; if no probe lands in the grid a single result with cell_valid low and
// last high is sent. Registers are written through the plain write port; the user
// must do so only while the block is idle, which the block does not enforce.
// Sequence: each item first passes through the cell computation (nine axis
// entries, each stepping through the sub, mul, fin and scl states and sharing
// the one 32x32 multiplier), then the 27-probe scan, a flush and a return to
// idle. With a single cell hit, the first result appears only after the flush.
// One item is worked on at a time; the next is taken while the last result
// still waits in the output register.
// A receiver stall holds the output register and, once a further result is
// ready, holds the scan. Reset returns the controller to idle, empties the output
// and loads the register reset values.
`default_nettype none

module grid_cell_binning #(
  parameter int unsigned MAX_SIDE_CELLS = gcb_pkg::MaxSideCellsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [15:0]        entity_id_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic [30:0]        radius_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [15:0]             owner_id_o,
  output logic [17:0]             cell_index_o,
  output logic                    cell_valid_o,
  output logic                    last_o
);

  gcb_pkg::cmd_t    cmd;
  gcb_pkg::status_t status;

  gcb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  gcb_datapath #(
    .MAX_SIDE_CELLS(MAX_SIDE_CELLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .entity_id_i (entity_id_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .radius_i    (radius_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .owner_id_o  (owner_id_o),
    .cell_index_o(cell_index_o),
    .cell_valid_o(cell_valid_o),
    .last_o      (last_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // An accepted request keeps the block busy for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after accepting a request");

  // A result with no cell in range is always the final one of its item.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cell_valid_o |-> last_o && cell_index_o == '0)
    else $error("empty result is not a final zero-index result");

  // The scan never pushes a result while a new item is being loaded.
  a_push_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !cmd.scan_adv && !cmd.flush)
    else $error("result pushed while loading a new item");

endmodule

`default_nettype wire

>>> hw/rtl/gcb_ctrl.sv
// Controller state machine for grid cell binning: sequences the per-axis cell
// computation, the probe scan and the final flush. Depends on gcb_pkg.
`default_nettype none

module gcb_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire gcb_pkg::status_t status_i,
  output gcb_pkg::cmd_t        cmd_o
);

  gcb_pkg::state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [1:0] sgn_q, sgn_d;
  logic [4:0] probe_q, probe_d;
  logic       scan_adv;
  logic       last_entry;

  // A scan step stalls only when a new hit must push out the pending one and the output register is still full.
  assign scan_adv = !(status_i.probe_hit && status_i.pend_valid && !status_i.out_free);
  assign last_entry = (axis_q == gcb_pkg::AXIS_Z) && (sgn_q == gcb_pkg::SGN_POS);

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    axis_d = axis_q;
    sgn_d = sgn_q;
    probe_d = probe_q;
    case (state_q)
      gcb_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = gcb_pkg::S_SUB;
          axis_d = gcb_pkg::AXIS_X;
          sgn_d = gcb_pkg::SGN_NEG;
        end
      end
      gcb_pkg::S_SUB: state_d = gcb_pkg::S_MUL;
      gcb_pkg::S_MUL: state_d = gcb_pkg::S_FIN;
      gcb_pkg::S_FIN: state_d = gcb_pkg::S_SCL;
      gcb_pkg::S_SCL: begin
        if (last_entry) begin
          state_d = gcb_pkg::S_SCAN;
          probe_d = '0;
        end else begin
          state_d = gcb_pkg::S_SUB;
          if (sgn_q == gcb_pkg::SGN_POS) begin
            sgn_d = gcb_pkg::SGN_NEG;
            axis_d = axis_q + 2'd1;
          end else begin
            sgn_d = sgn_q + 2'd1;
          end
        end
      end
      gcb_pkg::S_SCAN: begin
        if (scan_adv) begin
          if (probe_q == gcb_pkg::LAST_PROBE) begin
            state_d = gcb_pkg::S_FLUSH;
          end else begin
            probe_d = probe_q + 5'd1;
          end
        end
      end
      gcb_pkg::S_FLUSH: begin
        if (status_i.out_free) begin
          state_d = gcb_pkg::S_IDLE;
        end
      end
      default: state_d = gcb_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    cmd_o.axis = axis_q;
    cmd_o.sgn = sgn_q;
    cmd_o.probe = probe_q;
    in_ready_o = 1'b0;
    case (state_q)
      gcb_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      gcb_pkg::S_SUB: cmd_o.sub = 1'b1;
      gcb_pkg::S_MUL: cmd_o.mul = 1'b1;
      gcb_pkg::S_FIN: cmd_o.fin = 1'b1;
      gcb_pkg::S_SCL: cmd_o.scl = 1'b1;
      gcb_pkg::S_SCAN: cmd_o.scan_adv = scan_adv;
      gcb_pkg::S_FLUSH: cmd_o.flush = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcb_pkg::S_IDLE;
      axis_q <= gcb_pkg::AXIS_X;
      sgn_q <= gcb_pkg::SGN_NEG;
      probe_q <= '0;
    end else begin
      state_q <= state_d;
      axis_q <= axis_d;
      sgn_q <= sgn_d;
      probe_q <= probe_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/gcb_datapath.sv
// Datapath for grid cell binning: configuration registers, the shared cell
// multiplier, per-axis cell table, duplicate check and output register.
// Depends on gcb_pkg.
`default_nettype none

module gcb_datapath #(
  parameter int unsigned MAX_SIDE_CELLS = gcb_pkg::MaxSideCellsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [31:0]      cfg_data_i,
  input  wire logic [15:0]      entity_id_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic [30:0]      radius_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output logic [15:0]           owner_id_o,
  output logic [17:0]           cell_index_o,
  output logic                  cell_valid_o,
  output logic                  last_o,
  input  wire gcb_pkg::cmd_t    cmd_i,
  output gcb_pkg::status_t      status_o
);

  localparam int unsigned NW = $clog2(MAX_SIDE_CELLS + 1);
  localparam int unsigned SW = 3 * NW + 20;

  // Configuration.
  logic signed [31:0] org_x_q, org_y_q, org_z_q;
  logic [31:0] scale_q;
  logic [6:0]  side_q;

  // Item and per-entry work registers.
  logic [15:0] id_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic [30:0] rad_q;
  logic [NW-1:0] n_q;
  logic [2*NW-1:0] n2_q;
  logic [33:0] mag_q;
  logic        neg_q;
  logic [63:0] prod_q;
  logic [NW-1:0] coord_q;
  logic          cvalid_q;
  logic [SW-1:0] sc_q [3][3];
  logic          v_q [3][3];

  // Result staging.
  logic        pend_valid_q;
  logic [17:0] pend_idx_q;
  logic        out_valid_q;
  logic [15:0] out_id_q;
  logic [17:0] out_idx_q;
  logic        out_cv_q;
  logic        out_last_q;

  logic [8:0]  side_ext;
  logic [NW-1:0] n_sat;
  logic signed [34:0] pos_sel, org_sel, rad_sel, diff;
  logic [34:0] mag_full;
  logic [34:0] q_full;
  logic        entry_ok;
  logic [2*NW-1:0] factor;
  logic [SW-1:0] scaled;
  gcb_pkg::probe_sign_t ps;
  logic        hit;
  logic [SW-1:0] idx_sum;
  logic [15:0] eqm [3];
  logic        push_out;
  logic        out_free;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      scale_q <= 32'd65536;
      side_q <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gcb_pkg::REG_ORIGIN_X: org_x_q <= cfg_data_i;
        gcb_pkg::REG_ORIGIN_Y: org_y_q <= cfg_data_i;
        gcb_pkg::REG_ORIGIN_Z: org_z_q <= cfg_data_i;
        gcb_pkg::REG_CELL_SCALE: scale_q <= cfg_data_i;
        gcb_pkg::REG_CELLS_PER_SIDE: side_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Saturate the cell count to the grid size this instance supports.
  assign side_ext = 9'(side_q);
  assign n_sat = (side_ext > 9'(MAX_SIDE_CELLS)) ? NW'(MAX_SIDE_CELLS) : NW'(side_ext);

  // Probe offset on one axis: position plus signed radius minus origin.
  always_comb begin
    case (cmd_i.axis)
      gcb_pkg::AXIS_Y: begin
        pos_sel = 35'(py_q);
        org_sel = 35'(org_y_q);
      end
      gcb_pkg::AXIS_Z: begin
        pos_sel = 35'(pz_q);
        org_sel = 35'(org_z_q);
      end
      default: begin
        pos_sel = 35'(px_q);
        org_sel = 35'(org_x_q);
      end
    endcase
    case (cmd_i.sgn)
      gcb_pkg::SGN_NEG: rad_sel = -$signed({4'b0, rad_q});
      gcb_pkg::SGN_POS: rad_sel = $signed({4'b0, rad_q});
      default: rad_sel = '0;
    endcase
    diff = pos_sel + rad_sel - org_sel;
    mag_full = diff[34] ? 35'(-diff) : 35'(diff);
  end

  // Integer part of the magnitude times the scale, then the range test.
  assign q_full = 35'(mag_q[33:32] * scale_q) + 35'(prod_q[63:32]);
  assign entry_ok = (!neg_q || q_full == '0) && (q_full < 35'(n_q));

  // Each axis is weighted by its place in the linear index.
  always_comb begin
    case (cmd_i.axis)
      gcb_pkg::AXIS_Y: factor = n2_q;
      gcb_pkg::AXIS_Z: factor = (2*NW)'(n_q);
      default: factor = (2*NW)'(1);
    endcase
    scaled = SW'(coord_q * factor);
  end

  // Probe lookup, duplicate test and linear index.
  always_comb begin
    ps = gcb_pkg::probe_sign(cmd_i.probe);
    for (int a = 0; a < 3; a++) begin
      eqm[a] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          eqm[a][{2'(i), 2'(j)}] = v_q[a][i] && v_q[a][j] && (sc_q[a][i] == sc_q[a][j]);
        end
      end
    end
    hit = v_q[0][ps.sx] && v_q[1][ps.sy] && v_q[2][ps.sz] &&
          !gcb_pkg::probe_is_dup(cmd_i.probe, eqm[0], eqm[1], eqm[2]);
    idx_sum = sc_q[0][ps.sx] + sc_q[1][ps.sy] + sc_q[2][ps.sz];
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign push_out = (cmd_i.scan_adv && hit && pend_valid_q) || cmd_i.flush;

  // Item capture and arithmetic pipeline registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q <= entity_id_i;
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
      rad_q <= radius_i;
      n_q <= n_sat;
    end
    if (cmd_i.sub) begin
      mag_q <= mag_full[33:0];
      neg_q <= diff[34];
      n2_q <= n_q * n_q;
    end
    if (cmd_i.mul) begin
      prod_q <= mag_q[31:0] * scale_q;
    end
    if (cmd_i.fin) begin
      coord_q <= q_full[NW-1:0];
      cvalid_q <= entry_ok;
    end
    if (cmd_i.scl) begin
      sc_q[cmd_i.axis][cmd_i.sgn] <= scaled;
      v_q[cmd_i.axis][cmd_i.sgn] <= cvalid_q;
    end
    if (cmd_i.scan_adv && hit) begin
      pend_idx_q <= idx_sum[17:0];
    end
    if (push_out) begin
      out_id_q <= id_q;
      out_idx_q <= pend_valid_q ? pend_idx_q : '0;
      out_cv_q <= pend_valid_q;
      out_last_q <= cmd_i.flush;
    end
  end

  // Pending and output valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.scan_adv && hit) begin
        pend_valid_q <= 1'b1;
      end
      if (push_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.probe_hit = hit;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign owner_id_o = out_id_q;
  assign cell_index_o = out_idx_q;
  assign cell_valid_o = out_cv_q;
  assign last_o = out_last_q;

endmodule

`default_nettype wire

>>> bench/grid_cell_binning_test.sv
// Self-checking testbench for the grid cell binning block: drives entities with
// random and directed positions, predicts the binned cells and compares results.
// Depends on gcb_pkg and the grid_cell_binning RTL.
`default_nettype none

module grid_cell_binning_test;

  typedef struct packed {
    logic [15:0] owner_id;
    logic [17:0] cell_index;
    logic        cell_valid;
    logic        last;
  } cell_result_t;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 100;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [15:0] entity_id_i;
  logic signed [31:0] pos_x_i;
  logic signed [31:0] pos_y_i;
  logic signed [31:0] pos_z_i;
  logic [30:0] radius_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [15:0] owner_id_o;
  logic [17:0] cell_index_o;
  logic cell_valid_o;
  logic last_o;

  // Shadow copy of the grid registers.
  logic signed [31:0] grid_org_x, grid_org_y, grid_org_z;
  logic [31:0] grid_scale;
  logic [6:0] grid_side;

  cell_result_t expected_cells[$];
  int mismatch_count;
  int idle_cycles;
  bit sink_stalls;
  bit source_gaps;

  grid_cell_binning dut (.*);

  // Clock with a period of two time units.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Appends one predicted result to the end of the expected queue.
  function automatic void add_expected(input cell_result_t r);
    expected_cells = {expected_cells, r};
  endfunction

  // Cell coordinate along one axis; returns 0 when the probe falls off the grid.
  function automatic bit axis_cell(input logic signed [31:0] center, input logic [30:0] rad,
                                   input int sgn, input logic signed [31:0] org,
                                   input int unsigned n, output int unsigned cell_coord);
    longint d;
    longint unsigned m, q;
    bit neg;
    d = longint'(center) + sgn * longint'({1'b0, rad}) - longint'(org);
    neg = d < 0;
    m = neg ? longint'(-d) : d;
    q = (m >> 32) * grid_scale + (((m & 64'hFFFF_FFFF) * grid_scale) >> 32);
    cell_coord = 32'(q);
    if (neg && q != 0) return 0;
    return q < n;
  endfunction

  // Works out the distinct cells touched by the 27 probes, in first-hit order.
  task automatic predict_cells(input logic [15:0] id, input logic signed [31:0] px,
                               input logic signed [31:0] py, input logic signed [31:0] pz,
                               input logic [30:0] rad);
    int unsigned n, cx, cy, cz;
    logic [17:0] idx;
    logic [17:0] hits[$];
    int sx, sy, sz;
    gcb_pkg::probe_sign_t s;
    cell_result_t r;
    n = (grid_side > gcb_pkg::MaxSideCellsDefault) ? gcb_pkg::MaxSideCellsDefault : grid_side;
    for (int p = 0; p < gcb_pkg::ProbeCount; p++) begin
      s = gcb_pkg::probe_sign(5'(p));
      sx = int'(s.sx) - 1;
      sy = int'(s.sy) - 1;
      sz = int'(s.sz) - 1;
      if (!axis_cell(px, rad, sx, grid_org_x, n, cx)) continue;
      if (!axis_cell(py, rad, sy, grid_org_y, n, cy)) continue;
      if (!axis_cell(pz, rad, sz, grid_org_z, n, cz)) continue;
      idx = 18'(cx + n * (cz + n * cy));
      if (idx inside {hits}) continue;
      hits = {hits, idx};
    end
    if (hits.size() == 0) begin
      r = '{id, 18'd0, 1'b0, 1'b1};
      add_expected(r);
    end else begin
      foreach (hits[k]) begin
        r = '{id, hits[k], 1'b1, k == hits.size() - 1};
        add_expected(r);
      end
    end
  endtask

  // Writes one register while the block is idle and tracks it in the shadow copy.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      gcb_pkg::REG_ORIGIN_X: grid_org_x = data;
      gcb_pkg::REG_ORIGIN_Y: grid_org_y = data;
      gcb_pkg::REG_ORIGIN_Z: grid_org_z = data;
      gcb_pkg::REG_CELL_SCALE: grid_scale = data;
      gcb_pkg::REG_CELLS_PER_SIDE: grid_side = data[6:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                          input logic [31:0] scale, input logic [6:0] side);
    write_reg(gcb_pkg::REG_ORIGIN_X, ox);
    write_reg(gcb_pkg::REG_ORIGIN_Y, oy);
    write_reg(gcb_pkg::REG_ORIGIN_Z, oz);
    write_reg(gcb_pkg::REG_CELL_SCALE, scale);
    write_reg(gcb_pkg::REG_CELLS_PER_SIDE, {25'd0, side});
  endtask

  // Sends one entity request, with an optional random gap before it. Valid is
  // left high after acceptance; the next request or the drain takes it down.
  task automatic send_entity(input logic [15:0] id, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz,
                             input logic [30:0] rad);
    if (source_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    entity_id_i <= id;
    pos_x_i <= px;
    pos_y_i <= py;
    pos_z_i <= pz;
    radius_i <= rad;
    predict_cells(id, px, py, pz, rad);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Waits until every predicted result has come back, then lets the block settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Positions near the origin in Q16.16, a few cells wide.
  function automatic logic [31:0] near_pos();
    return 32'($signed($urandom_range(0, 32'h000C_0000)) - 32'sh0002_0000);
  endfunction

  task automatic test_reset_grid();
    send_entity(16'h0000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 31'd0);
    send_entity(16'hFFFF, 32'hFFFF_8000, 32'h0, 32'h0, 31'h0000_4000);
    wait_drained();
  endtask

  task automatic test_directed();
    // Eight-cell grid with unit cells.
    set_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 7'd8);
    send_entity(16'h1234, 32'h0004_0000, 32'h0004_0000, 32'h0004_0000, 31'h0001_0000);
    send_entity(16'h0001, 32'hFFFF_FFFF, 32'h0, 32'h0, 31'd0);
    send_entity(16'h0002, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    send_entity(16'h0003, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_entity(16'h0004, 32'h0007_FFFF, 32'h0, 32'h0007_FFFF, 31'h0000_8000);
    send_entity(16'h0005, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 31'h0000_C000);
    wait_drained();
    // Zero cell count drops every probe.
    set_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 7'd0);
    send_entity(16'h0006, 32'h0, 32'h0, 32'h0, 31'd0);
    wait_drained();
    // Oversized count saturates, zero scale folds all probes to cell zero.
    set_grid(32'h0, 32'h0, 32'h0, 32'h0, 7'd127);
    send_entity(16'h0007, 32'h1234_5678, 32'h8765_4321, 32'h0, 31'h4000_0000);
    wait_drained();
    set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 7'd64);
    send_entity(16'h0008, 32'h8000_0000, 32'h8000_0010, 32'h8000_0020, 31'h0000_0008);
    send_entity(16'h0009, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    wait_drained();
    set_grid(32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_0001, 7'd1);
    send_entity(16'h000A, 32'h7FFF_FFFF, 32'h0, 32'h0, 31'h0000_1000);
    // An unknown register index must leave the grid alone.
    wait_drained();
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h0);
    send_entity(16'h000B, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_0000, 31'd0);
    wait_drained();
  endtask

  // Random entities over several grid settings, mostly landing inside the grid.
  task automatic test_random(input int count, input bit gaps);
    logic [31:0] scale;
    source_gaps = gaps;
    sink_stalls = gaps;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        wait_drained();
        scale = ($urandom_range(0, 3) == 0) ? $urandom() : 32'h0001_0000 << $urandom_range(0, 2);
        set_grid(32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000),
                 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000),
                 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000),
                 scale, 7'($urandom_range(1, 70)));
      end
      if ($urandom_range(0, 9) == 0)
        send_entity(16'($urandom()), $urandom(), $urandom(), $urandom(), 31'($urandom()));
      else
        send_entity(16'($urandom()), near_pos(), near_pos(), near_pos(),
                    31'($urandom_range(0, 32'h0003_0000)));
    end
  endtask

  // Random receiver stalls in bursts.
  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each accepted result request with the oldest prediction.
  always @(posedge clk_i) begin
    cell_result_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{owner_id_o, cell_index_o, cell_valid_o, last_o};
      if (expected_cells.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result: %p", got);
      end else begin
        want = expected_cells.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    mismatch_count = 0;
    sink_stalls = 1'b1;
    source_gaps = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    entity_id_i = '0;
    pos_x_i = '0;
    pos_y_i = '0;
    pos_z_i = '0;
    radius_i = '0;
    grid_org_x = '0;
    grid_org_y = '0;
    grid_org_z = '0;
    grid_scale = 32'h0001_0000;
    grid_side = 7'd1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_grid();
    test_directed();
    test_random(180, 1'b1);
    test_random(40, 1'b0);
    wait_drained();
    if (mismatch_count == 0 && expected_cells.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
